FILE: rtl/core/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types and constants of the line follower PID drive: motor codes,
// register indexes, reset values and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package lfpd_pkg;

	localparam int MOTOR_W    = 2;
	localparam int DUTY_W     = 8;
	localparam int GAIN_W     = 8;
	localparam int TICK_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DUTY_MAX   = 255;
	localparam int DUTY_SHIFT = 5;

	localparam logic [DUTY_W-1:0] RST_BASE_SPEED = 8'd150;
	localparam logic [GAIN_W-1:0] RST_GAIN_P     = 8'd100;
	localparam logic [GAIN_W-1:0] RST_GAIN_I     = 8'd5;
	localparam logic [GAIN_W-1:0] RST_GAIN_D     = 8'd10;
	localparam logic [TICK_W-1:0] RST_HALT_TICKS = 16'd200;

	typedef enum logic [MOTOR_W-1:0] {
		MOT_OFF = 2'd0,
		MOT_FWD = 2'd1,
		MOT_REV = 2'd2
	} motor_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_SPEED = 3'd0,
		CFG_GAIN_P     = 3'd1,
		CFG_GAIN_I     = 3'd2,
		CFG_GAIN_D     = 3'd3,
		CFG_HALT_TICKS = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SIDE_NONE  = 2'd0,
		SIDE_RIGHT = 2'd1,
		SIDE_LEFT  = 2'd2
	} side_t;

	typedef enum logic [2:0] {
		RES_FULL_FWD   = 3'd0,
		RES_TURN_RIGHT = 3'd1,
		RES_TURN_LEFT  = 3'd2,
		RES_HALT       = 3'd3,
		RES_PID        = 3'd4
	} res_kind_t;

	typedef enum logic [1:0] {
		MUL_P = 2'd0,
		MUL_I = 2'd1,
		MUL_D = 2'd2
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2
	} acc_op_t;

	typedef struct packed {
		logic      load;
		logic      div_step;
		logic      err_latch;
		logic      sum_upd;
		logic      timer_on;
		logic      timer_off;
		logic      halt_set;
		mul_sel_t  mul_sel;
		acc_op_t   acc_op;
		logic      emit;
		res_kind_t kind;
		logic      last;
	} lfpd_cmd_t;

	typedef struct packed {
		logic in_tick;
		logic in_none;
		logic halted;
		logic centred;
		logic lost_right;
		logic lost_left;
		logic halt_due;
		logic end_mark;
		logic out_free;
	} lfpd_sts_t;

endpackage

FILE: rtl/core/lfpd_if.sv
// ----------------------------------------------------------------------------
// lfpd_if
// Valid/ready channels of the line follower PID drive: sensor request in,
// motor result out.
// ----------------------------------------------------------------------------
interface lfpd_req_if #(
	parameter int SENSOR_COUNT = 8
);
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic [SENSOR_COUNT-1:0] sensor_bits;

	modport source(output valid, req_type, sensor_bits, input ready);
	modport sink(input valid, req_type, sensor_bits, output ready);
endinterface

interface lfpd_res_if
	import lfpd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [MOTOR_W-1:0] right_motor;
	logic [MOTOR_W-1:0] left_motor;
	logic [DUTY_W-1:0]  right_duty;
	logic [DUTY_W-1:0]  left_duty;
	logic               stopped;
	logic               last_of_run;

	modport source(output valid, right_motor, left_motor, right_duty, left_duty,
		stopped, last_of_run, input ready);
	modport sink(input valid, right_motor, left_motor, right_duty, left_duty,
		stopped, last_of_run, output ready);
endinterface

FILE: rtl/core/lfpd_datapath.sv
// ----------------------------------------------------------------------------
// lfpd_datapath
// Registers, sensor weighting, bit-serial divider, shared gain multiplier,
// accumulator, duty clamp and the result register.
// ----------------------------------------------------------------------------
module lfpd_datapath
	import lfpd_pkg::*;
#(
	parameter int SENSOR_COUNT = 8,
	parameter int SUM_WIDTH    = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_req_type,
	input  logic [SENSOR_COUNT-1:0] in_sensor_bits,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  lfpd_cmd_t               cmd,
	output lfpd_sts_t               sts,
	lfpd_res_if.source              res
);

	localparam int WSUM_MAX = SENSOR_COUNT * (SENSOR_COUNT + 1) / 2;
	localparam int WSUM_W   = $clog2(WSUM_MAX + 1);
	localparam int NUM_W    = WSUM_W + 4;
	localparam int CNT_W    = $clog2(SENSOR_COUNT + 1);
	localparam int REM_W    = CNT_W + 1;
	localparam int CENTER   = 8 * (SENSOR_COUNT + 1);
	localparam int E_W      = $clog2(CENTER - 15) + 1;
	localparam int D_W      = E_W + 1;
	localparam int PROD_W   = GAIN_W + 1 + SUM_WIDTH;
	localparam int ACC_W    = PROD_W + 2;

	localparam logic [SENSOR_COUNT-1:0] ALL_LIT = {SENSOR_COUNT{1'b1}};
	localparam logic [SENSOR_COUNT-1:0] TOP_BIT = {1'b1, {(SENSOR_COUNT-1){1'b0}}};
	localparam logic [SENSOR_COUNT-1:0] BOT_BIT = SENSOR_COUNT'(1);
	localparam logic [SENSOR_COUNT-1:0] MID_BITS =
		(SENSOR_COUNT'(1) << (SENSOR_COUNT / 2 - 1)) | (SENSOR_COUNT'(1) << (SENSOR_COUNT / 2));
	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	// configuration
	logic [DUTY_W-1:0] base_q;
	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [TICK_W-1:0] halt_ticks_q;

	// persistent state
	logic signed [E_W-1:0]       prev_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	side_t                       side_q;
	logic                        timer_q;
	logic [TICK_W-1:0]           ticks_q;
	logic                        halted_q;

	// per-sample working registers
	logic [SENSOR_COUNT-1:0] bits_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [REM_W-1:0]        rem_q;
	logic [NUM_W-1:0]        quo_q;
	logic signed [E_W-1:0]   e_q;
	logic signed [D_W-1:0]   d_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;

	// result register
	logic               out_valid_q;
	logic [MOTOR_W-1:0] out_rm_q, out_lm_q;
	logic [DUTY_W-1:0]  out_rd_q, out_ld_q;
	logic               out_stop_q, out_last_q;

	logic [CNT_W-1:0]          cnt_in;
	logic [WSUM_W-1:0]         wsum_in;
	logic [REM_W-1:0]          rem_shift;
	logic                      quo_bit;
	logic signed [NUM_W:0]     quo_s;
	logic signed [E_W-1:0]     e_new;
	logic signed [D_W-1:0]     d_new;
	logic signed [SUM_WIDTH:0] sum_ext;
	logic signed [SUM_WIDTH-1:0] sum_new;
	logic signed [SUM_WIDTH-1:0] mul_op;
	logic signed [GAIN_W:0]    mul_gain;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [ACC_W-1:0]   half;
	logic signed [ACC_W:0]     base_x, right_sum, left_sum;
	logic                      sample_load;

	function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [ACC_W:0] v);
		logic [DUTY_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > (ACC_W+1)'(DUTY_MAX)) begin
			r = DUTY_W'(DUTY_MAX);
		end else begin
			r = v[DUTY_W-1:0];
		end
		return r;
	endfunction

	// sensor count and weight sum
	always_comb begin
		cnt_in  = '0;
		wsum_in = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			if (in_sensor_bits[i]) begin
				cnt_in  = cnt_in + CNT_W'(1);
				wsum_in = wsum_in + WSUM_W'(i + 1);
			end
		end
	end

	assign sample_load = cmd.load && !in_req_type && !halted_q;

	// restoring divider step
	assign rem_shift = {rem_q[CNT_W-1:0], quo_q[NUM_W-1]};
	assign quo_bit   = rem_shift >= {1'b0, cnt_q};

	always_comb begin
		quo_s = $signed({1'b0, quo_q}) - $signed((NUM_W+1)'(CENTER));
		e_new = (cnt_q != '0) ? E_W'(quo_s) : prev_q;
		d_new = D_W'(e_new) - D_W'(prev_q);
	end

	always_comb begin
		sum_ext = (SUM_WIDTH+1)'(sum_q) + (SUM_WIDTH+1)'(e_q);
		if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
			sum_new = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_new = $signed(sum_ext[SUM_WIDTH-1:0]);
		end
	end

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_P: begin
				mul_op   = SUM_WIDTH'(e_q);
				mul_gain = $signed({1'b0, gain_p_q});
			end
			MUL_I: begin
				mul_op   = sum_q;
				mul_gain = $signed({1'b0, gain_i_q});
			end
			MUL_D: begin
				mul_op   = SUM_WIDTH'(d_q);
				mul_gain = $signed({1'b0, gain_d_q});
			end
			default: begin
				mul_op   = '0;
				mul_gain = '0;
			end
		endcase
		prod_d = mul_gain * mul_op;
	end

	always_comb begin
		half      = acc_q >>> DUTY_SHIFT;
		base_x    = (ACC_W+1)'($signed({1'b0, base_q}));
		right_sum = base_x + (ACC_W+1)'(half);
		left_sum  = base_x - (ACC_W+1)'(half);
	end

	always_comb begin
		sts.in_tick    = in_req_type;
		sts.in_none    = in_sensor_bits == '0;
		sts.halted     = halted_q;
		sts.centred    = (cnt_q != '0) && (e_q == '0) && ((bits_q & MID_BITS) == MID_BITS);
		sts.lost_right = (cnt_q == '0) && (side_q == SIDE_RIGHT);
		sts.lost_left  = (cnt_q == '0) && (side_q == SIDE_LEFT);
		sts.halt_due   = ticks_q > halt_ticks_q;
		sts.end_mark   = (bits_q == ALL_LIT) || (bits_q == (ALL_LIT & ~TOP_BIT))
			|| (bits_q == (ALL_LIT & ~BOT_BIT));
		sts.out_free   = !out_valid_q || res.ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= RST_BASE_SPEED;
			gain_p_q     <= RST_GAIN_P;
			gain_i_q     <= RST_GAIN_I;
			gain_d_q     <= RST_GAIN_D;
			halt_ticks_q <= RST_HALT_TICKS;
			prev_q       <= '0;
			sum_q        <= '0;
			side_q       <= SIDE_NONE;
			timer_q      <= 1'b0;
			ticks_q      <= '0;
			halted_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BASE_SPEED: base_q       <= cfg_data[DUTY_W-1:0];
					CFG_GAIN_P:     gain_p_q     <= cfg_data[GAIN_W-1:0];
					CFG_GAIN_I:     gain_i_q     <= cfg_data[GAIN_W-1:0];
					CFG_GAIN_D:     gain_d_q     <= cfg_data[GAIN_W-1:0];
					CFG_HALT_TICKS: halt_ticks_q <= cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load && in_req_type && !halted_q && timer_q && (ticks_q != '1)) begin
				ticks_q <= ticks_q + TICK_W'(1);
			end
			if (sample_load) begin
				if (in_sensor_bits[0]) begin
					side_q <= SIDE_RIGHT;
				end
				if (in_sensor_bits[SENSOR_COUNT-1]) begin
					side_q <= SIDE_LEFT;
				end
			end
			if (cmd.err_latch) begin
				prev_q <= e_new;
			end
			if (cmd.sum_upd) begin
				sum_q <= sum_new;
			end
			if (cmd.timer_on) begin
				timer_q <= 1'b1;
			end else if (cmd.timer_off) begin
				timer_q <= 1'b0;
			end
			if (cmd.halt_set) begin
				halted_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and result payload
	always_ff @(posedge clk) begin
		if (sample_load) begin
			bits_q <= in_sensor_bits;
			cnt_q  <= cnt_in;
			rem_q  <= '0;
			quo_q  <= {wsum_in, 4'b0000};
		end else if (cmd.div_step) begin
			rem_q <= quo_bit ? (rem_shift - {1'b0, cnt_q}) : rem_shift;
			quo_q <= {quo_q[NUM_W-2:0], quo_bit};
		end
		if (cmd.err_latch) begin
			e_q <= e_new;
			d_q <= d_new;
		end
		prod_q <= prod_d;
		unique case (cmd.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			default:  ;
		endcase
		if (cmd.emit) begin
			out_last_q <= cmd.last;
			unique case (cmd.kind)
				RES_FULL_FWD: begin
					out_rm_q   <= MOT_FWD;
					out_lm_q   <= MOT_FWD;
					out_rd_q   <= DUTY_W'(DUTY_MAX);
					out_ld_q   <= DUTY_W'(DUTY_MAX);
					out_stop_q <= 1'b0;
				end
				RES_TURN_RIGHT: begin
					out_rm_q   <= MOT_REV;
					out_lm_q   <= MOT_FWD;
					out_rd_q   <= DUTY_W'(DUTY_MAX);
					out_ld_q   <= DUTY_W'(DUTY_MAX);
					out_stop_q <= 1'b0;
				end
				RES_TURN_LEFT: begin
					out_rm_q   <= MOT_FWD;
					out_lm_q   <= MOT_REV;
					out_rd_q   <= DUTY_W'(DUTY_MAX);
					out_ld_q   <= DUTY_W'(DUTY_MAX);
					out_stop_q <= 1'b0;
				end
				RES_PID: begin
					out_rm_q   <= MOT_FWD;
					out_lm_q   <= MOT_FWD;
					out_rd_q   <= clamp_duty(right_sum);
					out_ld_q   <= clamp_duty(left_sum);
					out_stop_q <= 1'b0;
				end
				default: begin
					out_rm_q   <= MOT_OFF;
					out_lm_q   <= MOT_OFF;
					out_rd_q   <= '0;
					out_ld_q   <= '0;
					out_stop_q <= 1'b1;
				end
			endcase
		end
	end

	assign res.valid       = out_valid_q;
	assign res.right_motor = out_rm_q;
	assign res.left_motor  = out_lm_q;
	assign res.right_duty  = out_rd_q;
	assign res.left_duty   = out_ld_q;
	assign res.stopped     = out_stop_q;
	assign res.last_of_run = out_last_q;

endmodule

FILE: rtl/core/lfpd_ctrl.sv
// ----------------------------------------------------------------------------
// lfpd_ctrl
// Sequencer of the line follower PID drive: divider steps, error latch,
// result emission order and the multiply-accumulate of the PID terms.
// ----------------------------------------------------------------------------
module lfpd_ctrl
	import lfpd_pkg::*;
#(
	parameter int SENSOR_COUNT = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lfpd_sts_t sts,
	output lfpd_cmd_t cmd
);

	localparam int WSUM_MAX = SENSOR_COUNT * (SENSOR_COUNT + 1) / 2;
	localparam int NUM_W    = $clog2(WSUM_MAX + 1) + 4;
	localparam int DIVC_W   = $clog2(NUM_W);
	localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(NUM_W - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_ERR,
		S_FIRST,
		S_SECOND,
		S_MUL_P,
		S_MUL_I,
		S_MUL_D,
		S_ACC,
		S_PID_OUT,
		S_STOP
	} state_t;

	state_t            state_q, state_d;
	logic [DIVC_W-1:0] div_q, div_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_q   <= '0;
		end else begin
			state_q <= state_d;
			div_q   <= div_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		div_d   = div_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.in_tick) begin
						state_d = S_IDLE;
					end else if (sts.halted) begin
						state_d = S_STOP;
					end else if (sts.in_none) begin
						state_d = S_ERR;
					end else begin
						state_d = S_DIV;
						div_d   = DIV_LAST;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_q == '0) begin
					state_d = S_ERR;
				end else begin
					div_d = div_q - DIVC_W'(1);
				end
			end
			S_ERR: begin
				cmd.err_latch = 1'b1;
				state_d       = S_FIRST;
			end
			S_FIRST: begin
				if (sts.centred || sts.lost_right || sts.lost_left) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.last = !sts.halt_due && sts.end_mark;
						if (sts.centred) begin
							cmd.kind = RES_FULL_FWD;
						end else if (sts.lost_right) begin
							cmd.kind = RES_TURN_RIGHT;
						end else begin
							cmd.kind = RES_TURN_LEFT;
						end
						state_d = S_SECOND;
					end
				end else begin
					state_d = S_SECOND;
				end
			end
			S_SECOND: begin
				if (sts.halt_due) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.kind      = RES_HALT;
						cmd.last      = 1'b1;
						cmd.halt_set  = 1'b1;
						cmd.timer_off = 1'b1;
						state_d       = S_IDLE;
					end
				end else if (sts.end_mark) begin
					cmd.timer_on = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.timer_off = 1'b1;
					cmd.sum_upd   = 1'b1;
					state_d       = S_MUL_P;
				end
			end
			S_MUL_P: begin
				cmd.mul_sel = MUL_P;
				state_d     = S_MUL_I;
			end
			S_MUL_I: begin
				cmd.mul_sel = MUL_I;
				cmd.acc_op  = ACC_LOAD;
				state_d     = S_MUL_D;
			end
			S_MUL_D: begin
				cmd.mul_sel = MUL_D;
				cmd.acc_op  = ACC_ADD;
				state_d     = S_ACC;
			end
			S_ACC: begin
				cmd.acc_op = ACC_ADD;
				state_d    = S_PID_OUT;
			end
			S_PID_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = RES_PID;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_STOP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = RES_HALT;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/line_follower_pid_drive.sv
// ----------------------------------------------------------------------------
// line_follower_pid_drive
// Line follower PID motor drive: sensor samples and millisecond ticks in,
// motor direction and duty results out.
// ----------------------------------------------------------------------------
// A timer tick is taken while idle and gives no result. A sensor sample
// is loaded, then passes the bit-serial divider that forms the weighted
// sensor mean, one step per quotient bit (10 quotient bits for 8 sensors),
// then the error latch and two result slots. A sample that ends on an
// end-of-line mark or a halt is done there. A PID sample then passes the
// shared gain multiplier and accumulator (states MUL_P, MUL_I, MUL_D and
// ACC) and its own result slot. A sample with no sensor lit skips the
// divider. A halted block answers a sample from its stop state. One item
// is in work at a time.
// Results leave through an output register, so the next item is taken while
// the last result still waits; a stalled output holds the sequencer at the
// next result slot. Configuration is taken at any cycle but should be
// written only when idle.
// ----------------------------------------------------------------------------
module line_follower_pid_drive
	import lfpd_pkg::*;
#(
	parameter int SENSOR_COUNT = 8,
	parameter int SUM_WIDTH    = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lfpd_req_if.sink              req,
	lfpd_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	lfpd_cmd_t cmd;
	lfpd_sts_t sts;
	logic      in_ready;

	assign req.ready = in_ready;

	lfpd_ctrl #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lfpd_datapath #(
		.SENSOR_COUNT(SENSOR_COUNT),
		.SUM_WIDTH   (SUM_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_req_type   (req.req_type),
		.in_sensor_bits(req.sensor_bits),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.res           (res)
	);

endmodule
